// ===== rtl/core/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// shared types and constants of the timer queue with earliest-deadline compare
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int TIMER_SLOTS_DEF = 16;

	localparam logic [2:0] ACT_REGISTER = 3'd0;
	localparam logic [2:0] ACT_DELETE   = 3'd1;
	localparam logic [2:0] ACT_ARM      = 3'd2;
	localparam logic [2:0] ACT_DISARM   = 3'd3;
	localparam logic [2:0] ACT_TIMEOUT  = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  slot;
		logic [63:0] deadline;
		logic [63:0] now_time;
	} in_t;

	typedef struct packed {
		logic        fired_valid;
		logic [3:0]  fired_slot;
		logic        reprogram;
		logic [63:0] compare_value;
		logic        last;
	} out_t;

endpackage

// ===== rtl/core/stq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ram
// generic single-write single-read memory with registered read data
// ----------------------------------------------------------------------------
module stq_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/stq_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_engine
// request decode, slot mark update and sequential scan of the deadline memory
// ----------------------------------------------------------------------------
module stq_engine #(
	parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF,
	parameter int IDX_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  stq_pkg::in_t       req,
	output logic               res_valid,
	output stq_pkg::out_t      res,
	input  logic               out_free,
	output logic               ram_we,
	output logic [IDX_W-1:0]   ram_waddr,
	output logic [63:0]        ram_wdata,
	output logic               ram_re,
	output logic [IDX_W-1:0]   ram_raddr,
	input  logic [63:0]        ram_rdata
);

	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLOSE
	} state_t;

	state_t                 state_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIMER_SLOTS-1:0] pend_q;
	logic [63:0]            cmp_q;
	logic [63:0]            min_q;
	logic                   found_q;
	logic                   timeout_q;
	logic [63:0]            now_q;
	logic [CNT_W-1:0]       issue_q;
	logic                   v_s1;
	logic [IDX_W-1:0]       idx_s1;

	logic                   accept;
	logic                   slot_ok;
	logic [IDX_W-1:0]       slot_ix;
	logic                   issue_done;
	logic                   eligible;
	logic                   fire;
	logic                   proc;
	logic                   adv;
	logic                   close_go;
	logic                   reprog;

	assign req_ready  = (state_q == ST_IDLE);
	assign accept     = req_valid && req_ready;
	assign slot_ok    = 32'(req.slot) < 32'(TIMER_SLOTS);
	assign slot_ix    = IDX_W'(req.slot);
	assign issue_done = (issue_q == CNT_W'(TIMER_SLOTS));

	assign eligible = v_s1 && valid_q[idx_s1] && pend_q[idx_s1];
	assign fire     = timeout_q && eligible && (ram_rdata <= now_q);
	assign proc     = v_s1 && out_free;
	assign adv      = !v_s1 || proc;
	assign close_go = (state_q == ST_CLOSE) && out_free;
	assign reprog   = found_q && (min_q != cmp_q);

	assign ram_we    = accept && (req.action == stq_pkg::ACT_ARM) && slot_ok && valid_q[slot_ix];
	assign ram_waddr = slot_ix;
	assign ram_wdata = req.deadline;
	assign ram_re    = (state_q == ST_SCAN) && !issue_done && adv;
	assign ram_raddr = issue_q[IDX_W-1:0];

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (proc && fire) begin
			res_valid       = 1'b1;
			res.fired_valid = 1'b1;
			res.fired_slot  = 4'(idx_s1);
		end else if (close_go) begin
			res_valid         = 1'b1;
			res.reprogram     = reprog;
			res.compare_value = reprog ? min_q : cmp_q;
			res.last          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			pend_q    <= '0;
			cmp_q     <= '0;
			min_q     <= '0;
			found_q   <= 1'b0;
			timeout_q <= 1'b0;
			now_q     <= '0;
			issue_q   <= '0;
			v_s1      <= 1'b0;
			idx_s1    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_SCAN;
						found_q   <= 1'b0;
						issue_q   <= '0;
						v_s1      <= 1'b0;
						timeout_q <= (req.action == stq_pkg::ACT_TIMEOUT);
						now_q     <= req.now_time;
						if (slot_ok) begin
							case (req.action)
								stq_pkg::ACT_REGISTER: begin
									valid_q[slot_ix] <= 1'b1;
									pend_q[slot_ix]  <= 1'b0;
								end
								stq_pkg::ACT_DELETE: begin
									valid_q[slot_ix] <= 1'b0;
									pend_q[slot_ix]  <= 1'b0;
								end
								stq_pkg::ACT_ARM: begin
									if (valid_q[slot_ix]) begin
										pend_q[slot_ix] <= 1'b1;
									end
								end
								stq_pkg::ACT_DISARM: begin
									if (valid_q[slot_ix]) begin
										pend_q[slot_ix] <= 1'b0;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_SCAN: begin
					if (proc) begin
						if (fire) begin
							pend_q[idx_s1] <= 1'b0;
						end else if (eligible && (!found_q || ram_rdata < min_q)) begin
							found_q <= 1'b1;
							min_q   <= ram_rdata;
						end
					end
					if (ram_re) begin
						issue_q <= issue_q + CNT_W'(1);
						idx_s1  <= ram_raddr;
						v_s1    <= 1'b1;
					end else if (proc) begin
						v_s1 <= 1'b0;
					end
					if (issue_done && adv) begin
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					if (close_go) begin
						if (reprog) begin
							cmp_q <= min_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/software_timer_queue_min_deadline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_queue_min_deadline
// timer slot table with expiry reporting and earliest-deadline compare update
// ----------------------------------------------------------------------------
// one request at a time: the deadline memory is scanned one slot per cycle
// through its single read port while the output is not stalled, and a new
// request is accepted only after the closing transaction has been handed on
// each fire transaction is registered at the output after its slot's read
// data returns, and the closing transaction follows once the scan is done
// reset clears the valid and pending marks and the compare value, not the memory
module software_timer_queue_min_deadline #(
	parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  stq_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output stq_pkg::out_t out_data
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	logic             res_valid;
	stq_pkg::out_t    res;
	logic             out_free;
	logic             out_valid_q;
	stq_pkg::out_t    out_q;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [63:0]      ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [63:0]      ram_rdata;

	stq_engine #(
		.TIMER_SLOTS(TIMER_SLOTS),
		.IDX_W      (IDX_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (in_data),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	stq_ram #(
		.WIDTH (64),
		.DEPTH (TIMER_SLOTS),
		.ADDR_W(IDX_W)
	) u_deadline_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

endmodule

// ===== rtl/core/stq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// port-level checks of the timer queue output transactions
// ----------------------------------------------------------------------------
module stq_port_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input stq_pkg::out_t out_data
);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a request is in flight");

	a_fire_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fired_valid |->
			!out_data.last && !out_data.reprogram && (out_data.compare_value == 64'd0))
		else $error("malformed fire transaction");

	a_close_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> !out_data.fired_valid && (out_data.fired_slot == 4'd0))
		else $error("malformed closing transaction");

endmodule

bind software_timer_queue_min_deadline stq_port_checker u_stq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

// ===== tb/sv/stq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// Watches both channels of the timer queue. Every request accepted on the
// input channel updates a private copy of the slot table and queues the
// expected fire transactions and the closing transaction. Every transaction
// accepted on the output channel is compared field by field with the oldest
// queued expectation.
// ----------------------------------------------------------------------------
module stq_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  stq_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  stq_pkg::out_t out_data,
	output int            errors,
	output int            outstanding
);

	localparam int SLOTS = stq_pkg::TIMER_SLOTS_DEF;

	logic          armed_valid [SLOTS];
	logic          armed_pend  [SLOTS];
	logic [63:0]   armed_time  [SLOTS];
	logic [63:0]   hw_compare;
	stq_pkg::out_t results_due [$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic queue_timer_results(input stq_pkg::in_t req);
		stq_pkg::out_t res;
		logic          found;
		logic          reprog;
		logic [63:0]   earliest;
		found    = 1'b0;
		reprog   = 1'b0;
		earliest = '0;
		case (req.action)
			stq_pkg::ACT_REGISTER: begin
				if (int'(req.slot) < SLOTS) begin
					armed_valid[req.slot] = 1'b1;
					armed_pend[req.slot]  = 1'b0;
					armed_time[req.slot]  = '0;
				end
			end
			stq_pkg::ACT_DELETE: begin
				if (int'(req.slot) < SLOTS) begin
					armed_valid[req.slot] = 1'b0;
					armed_pend[req.slot]  = 1'b0;
				end
			end
			stq_pkg::ACT_ARM: begin
				if (int'(req.slot) < SLOTS && armed_valid[req.slot]) begin
					armed_time[req.slot] = req.deadline;
					armed_pend[req.slot] = 1'b1;
				end
			end
			stq_pkg::ACT_DISARM: begin
				if (int'(req.slot) < SLOTS && armed_valid[req.slot])
					armed_pend[req.slot] = 1'b0;
			end
			stq_pkg::ACT_TIMEOUT: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (armed_valid[i] && armed_pend[i] && armed_time[i] <= req.now_time) begin
						armed_pend[i] = 1'b0;
						res = '0;
						res.fired_valid = 1'b1;
						res.fired_slot  = 4'(i);
						results_due.push_back(res);
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < SLOTS; i++) begin
			if (armed_valid[i] && armed_pend[i] && (!found || armed_time[i] < earliest)) begin
				earliest = armed_time[i];
				found    = 1'b1;
			end
		end
		if (found && earliest != hw_compare) begin
			hw_compare = earliest;
			reprog     = 1'b1;
		end
		res = '0;
		res.reprogram     = reprog;
		res.compare_value = hw_compare;
		res.last          = 1'b1;
		results_due.push_back(res);
	endtask

	task automatic check_transaction(input stq_pkg::out_t got);
		stq_pkg::out_t want;
		if (results_due.size() == 0) begin
			report_mismatch($sformatf("unexpected transaction %p", got));
		end else begin
			want = results_due.pop_front();
			if (got.fired_valid !== want.fired_valid)
				report_mismatch($sformatf("fired_valid %b, expected %b",
					got.fired_valid, want.fired_valid));
			if (got.fired_slot !== want.fired_slot)
				report_mismatch($sformatf("fired_slot %0d, expected %0d",
					got.fired_slot, want.fired_slot));
			if (got.reprogram !== want.reprogram)
				report_mismatch($sformatf("reprogram %b, expected %b",
					got.reprogram, want.reprogram));
			if (got.compare_value !== want.compare_value)
				report_mismatch($sformatf("compare_value %h, expected %h",
					got.compare_value, want.compare_value));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
		end
	endtask

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				armed_valid[i] = 1'b0;
				armed_pend[i]  = 1'b0;
				armed_time[i]  = '0;
			end
			hw_compare = '0;
			results_due.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready)
				check_transaction(out_data);
			if (in_valid && in_ready)
				queue_timer_results(in_data);
			outstanding = results_due.size();
		end
	end

endmodule

// ===== tb/sv/tb_software_timer_queue_min_deadline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_software_timer_queue_min_deadline
// Drives timer requests into the timer queue: a directed sequence over the
// slot extremes, every action and the corner cases, a full sweep in which
// all slots fire at once, then random traffic of all actions around a
// moving tick base. Both channels stall at random; the checker predicts and
// compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_software_timer_queue_min_deadline;

	localparam int          SLOTS           = stq_pkg::TIMER_SLOTS_DEF;
	localparam int          CYCLE_LIMIT     = 200000;
	localparam int          DRAIN_CYCLES    = 2 * SLOTS + 8;
	localparam int          RANDOM_REQUESTS = 95;
	localparam logic [2:0]  ACT_SPARE       = stq_pkg::ACT_TIMEOUT + 3'd1;
	localparam logic [63:0] TICK_MAX        = '1;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_ready;
	stq_pkg::in_t  in_data   = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	stq_pkg::out_t out_data;
	int            errors;
	int            outstanding;
	int            cycles    = 0;
	logic          steady    = 1'b0;
	logic [63:0]   tick_base;

	software_timer_queue_min_deadline u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	stq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.errors     (errors),
		.outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** software_timer_queue_min_deadline: FAILED **");
			$finish;
		end
	end

	function automatic stq_pkg::in_t timer_req(input logic [2:0] act, input logic [3:0] slot,
		input logic [63:0] dl, input logic [63:0] now);
		stq_pkg::in_t req;
		req.action   = act;
		req.slot     = slot;
		req.deadline = dl;
		req.now_time = now;
		return req;
	endfunction

	// entered and left at a falling edge
	task automatic send_request(input stq_pkg::in_t req);
		while (!steady && $urandom_range(99) < 15)
			@(negedge clk);
		in_valid = 1'b1;
		in_data  = req;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic make_random_request(output stq_pkg::in_t req);
		logic [2:0]  act;
		logic [63:0] dl;
		logic [63:0] now;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 35)      act = stq_pkg::ACT_ARM;
		else if (pick < 60) act = stq_pkg::ACT_TIMEOUT;
		else if (pick < 75) act = stq_pkg::ACT_REGISTER;
		else if (pick < 85) act = stq_pkg::ACT_DISARM;
		else if (pick < 93) act = stq_pkg::ACT_DELETE;
		else                act = ACT_SPARE + 3'($urandom_range(2));
		case ($urandom_range(9))
			0:       dl = {$urandom, $urandom};
			1:       dl = TICK_MAX - 64'($urandom_range(3));
			2:       dl = 64'($urandom_range(3));
			default: dl = tick_base + 64'($urandom_range(200));
		endcase
		case ($urandom_range(9))
			0:       now = {$urandom, $urandom};
			1:       now = TICK_MAX;
			default: now = tick_base + 64'($urandom_range(150));
		endcase
		if (act == stq_pkg::ACT_TIMEOUT)
			tick_base = tick_base + 64'($urandom_range(60));
		req = timer_req(act, 4'($urandom_range(15)), dl, now);
	endtask

	initial begin
		stq_pkg::in_t req;
		tick_base = {$urandom, $urandom} >> 2;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(timer_req(stq_pkg::ACT_TIMEOUT, 4'd0, '0, '0));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd3, TICK_MAX, '0));
		send_request(timer_req(stq_pkg::ACT_DISARM, 4'd3, '0, TICK_MAX));
		send_request(timer_req(stq_pkg::ACT_REGISTER, 4'd0, TICK_MAX, TICK_MAX));
		send_request(timer_req(stq_pkg::ACT_REGISTER, 4'd15, '0, '0));
		send_request(timer_req(stq_pkg::ACT_REGISTER, 4'd7, '0, '0));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd0, TICK_MAX, '0));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd15, '0, TICK_MAX));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd7, '0, '0));
		send_request(timer_req(stq_pkg::ACT_TIMEOUT, 4'd0, TICK_MAX, '0));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd15, 64'h8000_0000_0000_0000, '0));
		send_request(timer_req(stq_pkg::ACT_DISARM, 4'd15, '0, '0));
		send_request(timer_req(stq_pkg::ACT_REGISTER, 4'd0, '0, '0));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd0, 64'h5555_5555_5555_5555, '0));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd7, 64'hAAAA_AAAA_AAAA_AAAA, '0));
		send_request(timer_req(stq_pkg::ACT_TIMEOUT, 4'd9, '0, 64'h5555_5555_5555_5555));
		send_request(timer_req(stq_pkg::ACT_TIMEOUT, 4'd9, '0, TICK_MAX));
		send_request(timer_req(ACT_SPARE, 4'd15, TICK_MAX, TICK_MAX));
		send_request(timer_req(ACT_SPARE + 3'd1, 4'd5, 64'h1234_5678_9ABC_DEF0, '0));
		send_request(timer_req(ACT_SPARE + 3'd2, 4'd10, '0, 64'hFEDC_BA98_7654_3210));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd15, 64'h10, '0));
		send_request(timer_req(stq_pkg::ACT_DELETE, 4'd15, '0, '0));
		send_request(timer_req(stq_pkg::ACT_ARM, 4'd15, 64'h20, '0));
		send_request(timer_req(stq_pkg::ACT_DELETE, 4'd7, '0, '0));
		wait_drained();

		// every slot armed, then one timeout fires them all
		for (int i = 0; i < SLOTS; i++)
			send_request(timer_req(stq_pkg::ACT_REGISTER, 4'(i), '0, '0));
		for (int i = 0; i < SLOTS; i++)
			send_request(timer_req(stq_pkg::ACT_ARM, 4'(i),
				tick_base + 64'($urandom_range(500)), '0));
		send_request(timer_req(stq_pkg::ACT_TIMEOUT, 4'd0, '0, TICK_MAX));

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady = (i >= 50 && i < 85);
			if (i % 40 == 39)
				wait_drained();
			make_random_request(req);
			send_request(req);
		end
		steady = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("** software_timer_queue_min_deadline: PASSED **");
		else
			$display("** software_timer_queue_min_deadline: FAILED **");
		$finish;
	end

endmodule
